// ===== hw/rtl/tmsg_pkg.sv =====
`timescale 1ns / 1ps

package tmsg_pkg;

  localparam int TEXT_ROWS_DEF = 32;
  localparam int TEXT_COLS_DEF = 32;
  localparam int GLYPH_LINES   = 8;
  localparam int GLYPHS        = 256;
  localparam int FONT_DEPTH    = GLYPHS * GLYPH_LINES;
  localparam int FONT_AW       = $clog2(FONT_DEPTH);
  localparam int GL_W          = $clog2(GLYPH_LINES);

  localparam int ROW_W    = 6;
  localparam int K_W      = 6;
  localparam int MAX_COLS = 32;

  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OCC_W    = OQ_AW + 1;

  localparam logic [1:0] REG_BACK_PORCH = 2'd0;
  localparam logic [1:0] REG_ACTIVE     = 2'd1;
  localparam logic [1:0] REG_COLUMNS    = 2'd2;

  localparam logic [7:0] BACK_PORCH_RST = 8'd35;
  localparam logic [9:0] ACTIVE_RST     = 10'd480;
  localparam logic [5:0] COLUMNS_RST    = 6'd20;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_FRAME = 2'd1,
    MODE_TEXT  = 2'd2,
    MODE_FONT  = 2'd3
  } tmsg_mode_t;

  typedef struct packed {
    logic [7:0] back_porch;
    logic [9:0] active;
    logic [5:0] columns;
  } tmsg_cfg_t;

  typedef struct packed {
    logic             vld;
    logic [ROW_W-1:0] row;
    logic [K_W-1:0]   col;
    logic [GL_W-1:0]  gline;
    logic             last;
  } tmsg_issue_t;

  typedef struct packed {
    logic            text_we;
    logic            font_we;
    logic [4:0]      row;
    logic [4:0]      col;
    logic [7:0]      code;
    logic [GL_W-1:0] gline;
    logic [7:0]      bits;
  } tmsg_wr_t;

  typedef struct packed {
    logic [7:0] pixel_byte;
    logic [4:0] column;
    logic       last;
  } tmsg_res_t;

endpackage

// ===== hw/rtl/tmsg_ctrl.sv =====
`timescale 1ns / 1ps

module tmsg_ctrl #(
  parameter int TEXT_ROWS = tmsg_pkg::TEXT_ROWS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tmsg_pkg::tmsg_cfg_t cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_mode,
  input  logic [4:0]          in_row_addr,
  input  logic [4:0]          in_col_addr,
  input  logic [7:0]          in_char_code,
  input  logic [2:0]          in_glyph_line,
  input  logic [7:0]          in_glyph_bits,
  input  logic                out_fire,
  output tmsg_pkg::tmsg_issue_t issue,
  output tmsg_pkg::tmsg_wr_t  wr
);
  import tmsg_pkg::*;

  localparam int RW = (TEXT_ROWS > 1) ? $clog2(TEXT_ROWS) : 1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } st_t;

  st_t             st_r, st_nxt;
  logic [9:0]      line_r, line_nxt;
  logic [RW-1:0]   row_r, row_nxt;
  logic [7:0]      porch_r, porch_nxt;
  logic [K_W-1:0]  cols_r, cols_nxt;
  logic [K_W-1:0]  k_r, k_nxt;
  logic [GL_W-1:0] gl_r, gl_nxt;
  logic [RW-1:0]   erow_r, erow_nxt;
  logic [OCC_W-1:0] occ_r, occ_nxt;

  tmsg_mode_t     mode_c;
  logic           acc;
  logic           issue_go;
  logic           at_last;
  logic [9:0]     line_inc;
  logic [K_W-1:0] cols_sat;

  assign mode_c   = tmsg_mode_t'(in_mode);
  assign in_ready = (st_r == ST_IDLE);
  assign acc      = in_valid && in_ready;
  assign issue_go = (st_r == ST_EMIT) && (occ_r < OCC_W'(OQ_DEPTH));
  assign at_last  = (k_r == cols_r - K_W'(1));
  assign line_inc = line_r + 10'd1;
  assign cols_sat = (cfg.columns > K_W'(MAX_COLS)) ? K_W'(MAX_COLS) : cfg.columns;

  always_comb begin
    st_nxt    = st_r;
    line_nxt  = line_r;
    row_nxt   = row_r;
    porch_nxt = porch_r;
    cols_nxt  = cols_r;
    k_nxt     = k_r;
    gl_nxt    = gl_r;
    erow_nxt  = erow_r;
    case (st_r)
      ST_IDLE: begin
        if (acc) begin
          case (mode_c)
            MODE_FRAME: begin
              line_nxt  = '0;
              row_nxt   = '0;
              porch_nxt = cfg.back_porch;
            end
            MODE_TICK: begin
              if (porch_r != 8'd0) begin
                porch_nxt = porch_r - 8'd1;
              end else if (line_r < cfg.active) begin
                line_nxt = line_inc;
                if (line_inc[3:0] == 4'd0 && (32'(row_r) + 32'd1 < TEXT_ROWS)) begin
                  row_nxt = row_r + RW'(1);
                end
                cols_nxt = cols_sat;
                gl_nxt   = line_r[GL_W:1];
                erow_nxt = row_r;
                k_nxt    = '0;
                if (cols_sat != '0) begin
                  st_nxt = ST_EMIT;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_EMIT: begin
        if (issue_go) begin
          k_nxt = k_r + K_W'(1);
          if (at_last) begin
            st_nxt = ST_IDLE;
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    occ_nxt = occ_r;
    if (issue_go && !out_fire) begin
      occ_nxt = occ_r + OCC_W'(1);
    end else if (!issue_go && out_fire) begin
      occ_nxt = occ_r - OCC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      line_r  <= '0;
      row_r   <= '0;
      porch_r <= '0;
      occ_r   <= '0;
    end else begin
      st_r    <= st_nxt;
      line_r  <= line_nxt;
      row_r   <= row_nxt;
      porch_r <= porch_nxt;
      occ_r   <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cols_r <= cols_nxt;
    k_r    <= k_nxt;
    gl_r   <= gl_nxt;
    erow_r <= erow_nxt;
  end

  always_comb begin
    issue.vld   = issue_go;
    issue.row   = ROW_W'(erow_r);
    issue.col   = k_r;
    issue.gline = gl_r;
    issue.last  = at_last;
  end

  always_comb begin
    wr.text_we = acc && (mode_c == MODE_TEXT) && (32'(in_row_addr) < TEXT_ROWS);
    wr.font_we = acc && (mode_c == MODE_FONT);
    wr.row     = in_row_addr;
    wr.col     = in_col_addr;
    wr.code    = in_char_code;
    wr.gline   = in_glyph_line;
    wr.bits    = in_glyph_bits;
  end

endmodule

// ===== hw/rtl/tmsg_store.sv =====
`timescale 1ns / 1ps

module tmsg_store #(
  parameter int TEXT_ROWS = tmsg_pkg::TEXT_ROWS_DEF,
  parameter int TEXT_COLS = tmsg_pkg::TEXT_COLS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tmsg_pkg::tmsg_wr_t    wr,
  input  tmsg_pkg::tmsg_issue_t issue,
  output logic                  res_vld,
  output tmsg_pkg::tmsg_res_t   res
);
  import tmsg_pkg::*;

  localparam int TDEPTH = TEXT_ROWS * TEXT_COLS;
  localparam int TAW    = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;

  logic [7:0] text_mem [TDEPTH];
  logic [7:0] font_mem [FONT_DEPTH];

  logic [TAW-1:0]     twaddr, traddr;
  logic               t_wen;
  logic               oob;
  logic [7:0]         ch;
  logic [FONT_AW-1:0] fwaddr, fraddr;

  logic [7:0]      text_q_r;
  logic            s1_v_r;
  logic            s1_oob_r;
  logic [GL_W-1:0] s1_gl_r;
  logic [4:0]      s1_col_r;
  logic            s1_last_r;
  logic [7:0]      font_q_r;
  logic            s2_v_r;
  logic [4:0]      s2_col_r;
  logic            s2_last_r;

  assign t_wen  = wr.text_we && (32'(wr.col) < TEXT_COLS);
  assign twaddr = TAW'(32'(wr.row) * TEXT_COLS + 32'(wr.col));
  assign fwaddr = {wr.gline, wr.code};

  assign oob    = (32'(issue.col) >= TEXT_COLS);
  assign traddr = oob ? '0 : TAW'(32'(issue.row) * TEXT_COLS + 32'(issue.col));

  assign ch     = s1_oob_r ? 8'd0 : text_q_r;
  assign fraddr = {s1_gl_r, ch};

  always_ff @(posedge clk) begin
    if (t_wen) begin
      text_mem[twaddr] <= wr.code;
    end
    text_q_r <= text_mem[traddr];
  end

  always_ff @(posedge clk) begin
    if (wr.font_we) begin
      font_mem[fwaddr] <= wr.bits;
    end
    font_q_r <= font_mem[fraddr];
  end

  always_ff @(posedge clk) begin
    s1_oob_r  <= oob;
    s1_gl_r   <= issue.gline;
    s1_col_r  <= issue.col[4:0];
    s1_last_r <= issue.last;
    s2_col_r  <= s1_col_r;
    s2_last_r <= s1_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= issue.vld;
      s2_v_r <= s1_v_r;
    end
  end

  assign res_vld        = s2_v_r;
  assign res.pixel_byte = font_q_r;
  assign res.column     = s2_col_r;
  assign res.last       = s2_last_r;

endmodule

// ===== hw/rtl/text_mode_scanline_generator_core.sv =====
`timescale 1ns / 1ps

// Text-mode scan-line generator. Store writes, frame starts and line ticks
// that draw nothing leave in_ready high. A drawing line tick holds in_ready
// low until columns_per_line columns (capped at 32) are issued: the sequencer
// issues one column per cycle while the queue has room, into a text-memory
// read followed by a font-memory read, and the byte lands in a 4-entry output
// queue. Issue pauses while the queue and the reads in flight hold 4 bytes,
// so a stalled out_ready slows the line to the rate bytes are taken.
module text_mode_scanline_generator_core #(
  parameter int TEXT_ROWS = tmsg_pkg::TEXT_ROWS_DEF,
  parameter int TEXT_COLS = tmsg_pkg::TEXT_COLS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [4:0]  in_row_addr,
  input  logic [4:0]  in_col_addr,
  input  logic [7:0]  in_char_code,
  input  logic [2:0]  in_glyph_line,
  input  logic [7:0]  in_glyph_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_pixel_byte,
  output logic [4:0]  out_column,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tmsg_pkg::*;

  tmsg_cfg_t   cfg;
  logic [7:0]  bp_r;
  logic [9:0]  al_r;
  logic [5:0]  cpl_r;
  logic [1:0]  reg_idx;
  logic        cfg_we;

  tmsg_issue_t issue;
  tmsg_wr_t    wr;
  logic        res_vld;
  tmsg_res_t   res;
  logic        out_fire;

  tmsg_res_t      oq_r [OQ_DEPTH];
  logic [OQ_AW-1:0] wp_r, rp_r;
  logic [OQ_AW:0]   cnt_r, cnt_nxt;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bp_r  <= BACK_PORCH_RST;
      al_r  <= ACTIVE_RST;
      cpl_r <= COLUMNS_RST;
    end else if (cfg_we) begin
      case (reg_idx)
        REG_BACK_PORCH: bp_r  <= pwdata[7:0];
        REG_ACTIVE:     al_r  <= pwdata[9:0];
        REG_COLUMNS:    cpl_r <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BACK_PORCH: prdata = {24'd0, bp_r};
      REG_ACTIVE:     prdata = {22'd0, al_r};
      REG_COLUMNS:    prdata = {26'd0, cpl_r};
      default:        prdata = 32'd0;
    endcase
  end

  assign cfg.back_porch = bp_r;
  assign cfg.active     = al_r;
  assign cfg.columns    = cpl_r;

  tmsg_ctrl #(
    .TEXT_ROWS(TEXT_ROWS)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_row_addr   (in_row_addr),
    .in_col_addr   (in_col_addr),
    .in_char_code  (in_char_code),
    .in_glyph_line (in_glyph_line),
    .in_glyph_bits (in_glyph_bits),
    .out_fire      (out_fire),
    .issue         (issue),
    .wr            (wr)
  );

  tmsg_store #(
    .TEXT_ROWS(TEXT_ROWS),
    .TEXT_COLS(TEXT_COLS)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr),
    .issue   (issue),
    .res_vld (res_vld),
    .res     (res)
  );

  assign out_valid = (cnt_r != '0);
  assign out_fire  = out_valid && out_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (res_vld && !out_fire) begin
      cnt_nxt = cnt_r + (OQ_AW+1)'(1);
    end else if (!res_vld && out_fire) begin
      cnt_nxt = cnt_r - (OQ_AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (res_vld) begin
        wp_r <= wp_r + OQ_AW'(1);
      end
      if (out_fire) begin
        rp_r <= rp_r + OQ_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld) begin
      oq_r[wp_r] <= res;
    end
  end

  assign out_pixel_byte = oq_r[rp_r].pixel_byte;
  assign out_column     = oq_r[rp_r].column;
  assign out_last       = oq_r[rp_r].last;

endmodule

// ===== hw/rtl/tmsg_chk.sv =====
`timescale 1ns / 1ps

module tmsg_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_pixel_byte,
  input logic [4:0]  out_column,
  input logic        out_last,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [3:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);
  import tmsg_pkg::*;

  logic [4:0] exp_col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_col_r <= '0;
    end else if (out_valid && out_ready) begin
      exp_col_r <= out_last ? 5'd0 : out_column + 5'd1;
    end
  end

  a_col_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |-> out_column == exp_col_r)
    else $error("column out of sequence within a line");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_byte) &&
    $stable(out_column) && $stable(out_last))
    else $error("stalled result transfer changed");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

  a_bp_readback: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && paddr[3:2] == REG_BACK_PORCH |=>
    paddr[3:2] != REG_BACK_PORCH || prdata == {24'd0, $past(pwdata[7:0])})
    else $error("back porch register readback mismatch");

endmodule

bind text_mode_scanline_generator_core tmsg_chk u_tmsg_chk (.*);

// ===== bench/text_mode_scanline_generator_core_tb.sv =====
`timescale 1ns / 1ps

module text_mode_scanline_generator_core_tb;
  import tmsg_pkg::*;

  localparam int TEXT_CELLS    = TEXT_ROWS_DEF * TEXT_COLS_DEF;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 1000000;

  class scanline_model;
    logic [7:0] text_mem [TEXT_CELLS];
    logic [7:0] font_mem [FONT_DEPTH];
    logic [9:0] line_count;
    logic [4:0] text_row;
    logic [7:0] porch_left;
    logic [7:0] back_porch;
    logic [9:0] active;
    logic [5:0] columns;
    tmsg_res_t  pending_bytes[$];
    int         mismatches;

    function new();
      line_count = '0;
      text_row   = '0;
      porch_left = '0;
      back_porch = BACK_PORCH_RST;
      active     = ACTIVE_RST;
      columns    = COLUMNS_RST;
      mismatches = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_BACK_PORCH: back_porch = value[7:0];
        REG_ACTIVE:     active     = value[9:0];
        REG_COLUMNS:    columns    = value[5:0];
        default: ;
      endcase
    endfunction

    function int line_width();
      return (columns > MAX_COLS) ? MAX_COLS : int'(columns);
    endfunction

    function bit draws_next();
      return porch_left == 0 && line_count < active;
    endfunction

    function void take_item(tmsg_mode_t mode, logic [4:0] row, logic [4:0] col,
                            logic [7:0] code, logic [2:0] gline, logic [7:0] bits);
      int        n;
      int        k;
      logic [2:0] gr;
      logic [7:0] ch;
      tmsg_res_t byte_out;
      case (mode)
        MODE_FRAME: begin
          line_count = '0;
          text_row   = '0;
          porch_left = back_porch;
        end
        MODE_TEXT: text_mem[int'(row) * TEXT_COLS_DEF + int'(col)] = code;
        MODE_FONT: font_mem[int'(gline) * GLYPHS + int'(code)] = bits;
        default: begin
          if (porch_left != 0) begin
            porch_left = porch_left - 1'b1;
          end else if (line_count < active) begin
            n  = line_width();
            gr = line_count[3:1];
            for (k = 0; k < n; k++) begin
              ch = text_mem[int'(text_row) * TEXT_COLS_DEF + k];
              byte_out.pixel_byte = font_mem[int'(gr) * GLYPHS + int'(ch)];
              byte_out.column     = 5'(k);
              byte_out.last       = (k + 1 == n);
              pending_bytes.push_back(byte_out);
            end
            line_count = line_count + 1'b1;
            if (line_count[3:0] == 4'd0 && text_row != TEXT_ROWS_DEF - 1)
              text_row = text_row + 1'b1;
          end
        end
      endcase
    endfunction

    function void miss(string what, int want, int got);
      mismatches++;
      $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
    endfunction

    function void check_byte(logic [7:0] pixel, logic [4:0] column, logic last);
      tmsg_res_t want;
      if (pending_bytes.size() == 0) begin
        miss("unexpected transfer, column", -1, column);
        return;
      end
      want = pending_bytes.pop_front();
      if (pixel !== want.pixel_byte) miss("pixel_byte", want.pixel_byte, pixel);
      if (column !== want.column) miss("column", want.column, column);
      if (last !== want.last) miss("last", want.last, last);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_mode;
  logic [4:0]  in_row_addr;
  logic [4:0]  in_col_addr;
  logic [7:0]  in_char_code;
  logic [2:0]  in_glyph_line;
  logic [7:0]  in_glyph_bits;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_pixel_byte;
  logic [4:0]  out_column;
  logic        out_last;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  scanline_model model;
  bit            text_known [TEXT_CELLS];
  bit            font_known [FONT_DEPTH];
  bit            hold_req;
  bit            send_calm;
  int unsigned   cycle_count = 0;

  text_mode_scanline_generator_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_row_addr    (in_row_addr),
    .in_col_addr    (in_col_addr),
    .in_char_code   (in_char_code),
    .in_glyph_line  (in_glyph_line),
    .in_glyph_bits  (in_glyph_bits),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_byte (out_pixel_byte),
    .out_column     (out_column),
    .out_last       (out_last),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int pick_gap(inout bit calm);
    if ($urandom_range(0, 15) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 7);
  endfunction

  // small character set keeps the font cells a line needs few
  function automatic logic [7:0] pick_code();
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h41;
      default: return 8'h7E;
    endcase
  endfunction

  task automatic send_item(tmsg_mode_t m, logic [4:0] row, logic [4:0] col,
                           logic [7:0] code, logic [2:0] gline, logic [7:0] bits);
    int gap;
    gap = pick_gap(send_calm);
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid      = 1'b1;
    in_mode       = m;
    in_row_addr   = row;
    in_col_addr   = col;
    in_char_code  = code;
    in_glyph_line = gline;
    in_glyph_bits = bits;
    do @(posedge clk); while (!in_ready);
    model.take_item(m, row, col, code, gline, bits);
    if (m == MODE_TEXT) text_known[int'(row) * TEXT_COLS_DEF + int'(col)] = 1'b1;
    if (m == MODE_FONT) font_known[int'(gline) * GLYPHS + int'(code)] = 1'b1;
  endtask

  task automatic send_random(tmsg_mode_t m);
    send_item(m, 5'($urandom), 5'($urandom),
              (m == MODE_FONT) ? 8'($urandom) : pick_code(),
              3'($urandom), 8'($urandom));
  endtask

  // fills every text cell and glyph line the coming line will read, then ticks
  task automatic line_tick();
    int k;
    int slot;
    int glyph;
    if (model.draws_next()) begin
      for (k = 0; k < model.line_width(); k++) begin
        slot = int'(model.text_row) * TEXT_COLS_DEF + k;
        if (!text_known[slot])
          send_item(MODE_TEXT, model.text_row, 5'(k), pick_code(), 3'($urandom),
                    8'($urandom));
        glyph = int'(model.line_count[3:1]) * GLYPHS + int'(model.text_mem[slot]);
        if (!font_known[glyph])
          send_item(MODE_FONT, 5'($urandom), 5'($urandom), model.text_mem[slot],
                    model.line_count[3:1], 8'($urandom));
      end
    end
    send_random(MODE_TICK);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (model.pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    model.set_reg(idx, value);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic configure(logic [7:0] porch, logic [9:0] active, logic [5:0] cols);
    drain();
    write_reg(REG_BACK_PORCH, {24'd0, porch});
    write_reg(REG_ACTIVE, {22'd0, active});
    write_reg(REG_COLUMNS, {26'd0, cols});
  endtask

  task automatic random_items(int n);
    int pick;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) line_tick();
      else if (pick < 78) send_random(MODE_FRAME);
      else if (pick < 89) send_random(MODE_TEXT);
      else send_random(MODE_FONT);
    end
  endtask

  initial begin : byte_sink
    int stall;
    bit calm;
    calm = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_req) begin
        @(negedge clk);
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      stall = pick_gap(calm);
      repeat (stall) begin
        @(negedge clk);
        out_ready = 1'b0;
      end
      @(negedge clk);
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      model.check_byte(out_pixel_byte, out_column, out_last);
    end
  end

  initial begin : stimulus
    logic [9:0] act;
    logic [5:0] cols;
    model         = new();
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_mode       = MODE_TICK;
    in_row_addr   = '0;
    in_col_addr   = '0;
    in_char_code  = '0;
    in_glyph_line = '0;
    in_glyph_bits = '0;
    out_ready     = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: store extremes, porch lines, drawn lines, front porch
    configure(8'd2, 10'd4, 6'd3);
    send_item(MODE_TEXT, 5'd31, 5'd31, 8'hFF, 3'd7, 8'hFF);
    send_item(MODE_TEXT, 5'd0, 5'd0, 8'h00, 3'd0, 8'h00);
    send_item(MODE_TEXT, 5'd0, 5'd1, 8'hFF, 3'd0, 8'h00);
    send_item(MODE_FONT, 5'd31, 5'd31, 8'hFF, 3'd7, 8'hFF);
    send_item(MODE_FONT, 5'd0, 5'd0, 8'h00, 3'd0, 8'h00);
    send_item(MODE_FONT, 5'd0, 5'd0, 8'hFF, 3'd0, 8'h5A);
    send_random(MODE_FRAME);
    repeat (7) line_tick();

    // zero columns still count lines and move the text row
    configure(8'd0, 10'd1023, 6'd0);
    send_random(MODE_FRAME);
    repeat (40) line_tick();
    configure(8'd0, 10'd1023, 6'd32);
    hold_req = 1'b1;
    repeat (4) line_tick();
    configure(8'd0, 10'd0, 6'd32);
    repeat (3) line_tick();

    // longest back porch
    configure(8'd255, 10'd2, 6'd1);
    send_random(MODE_FRAME);
    repeat (12) line_tick();

    // column count above the cap
    configure(8'd1, 10'd40, 6'd63);
    send_random(MODE_FRAME);
    random_items(16);

    repeat (5) begin
      case ($urandom_range(0, 3))
        0: act = 10'd0;
        1: act = 10'd1023;
        default: act = 10'($urandom_range(1, 40));
      endcase
      case ($urandom_range(0, 4))
        0: cols = 6'd0;
        1: cols = 6'd32;
        2: cols = 6'($urandom_range(33, 63));
        default: cols = 6'($urandom_range(1, 8));
      endcase
      configure(8'($urandom_range(0, 3)), act, cols);
      send_random(MODE_FRAME);
      random_items(20);
    end

    drain();
    if (model.mismatches == 0 && model.pending_bytes.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
